// ----- hdl/tfir_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// tfir_pkg
// Shared types and constants for the transposed-form FIR filter.
// ----------------------------------------------------------------------------
package tfir_pkg;

    localparam int MAX_TAPS = 64;
    localparam int TAP_AW   = $clog2(MAX_TAPS);
    localparam int CNT_W    = TAP_AW + 1;
    localparam int SUM_W    = 40;
    localparam int CFG_W    = 7;
    localparam int SMP_W    = 16;
    localparam int PROD_W   = 2 * SMP_W;
    localparam int SH_W     = SUM_W + 1 - 15;

    localparam logic [CFG_W-1:0] TAP_COUNT_RST = CFG_W'(64);
    localparam logic             KIND_SAMPLE   = 1'b0;
    localparam logic             KIND_COEF     = 1'b1;

    typedef struct packed {
        logic                    kind;
        logic signed [SMP_W-1:0] sample;
        logic [5:0]              coef_index;
        logic signed [SMP_W-1:0] coef_value;
        logic                    block_end;
    } t_in_word;

    typedef struct packed {
        logic signed [SMP_W-1:0] filtered;
        logic                    clipped;
        logic                    last_of_block;
    } t_out_word;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_DONE
    } t_state;

endpackage

`default_nettype wire

// ----- hdl/transposed_fir_filter.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// transposed_fir_filter
// Transposed-form FIR on Q1.15 samples with one shared multiply-accumulate.
// ----------------------------------------------------------------------------
// A sample word holds the input busy from its acceptance until its result
// is loaded into the output register, so a new sample is not taken before
// the last one is through. The number of taps is tap_count clamped to 1..64.
// One multiply-accumulate unit walks the taps, one per cycle, through a
// three-stage read, multiply and add-write pipeline on the coefficient and
// partial-sum memories. A coefficient word is taken while idle and emits
// nothing. The output word is held in a register, so a new word is accepted
// while a result waits; a sample that finishes while the previous result
// still waits holds in its done state until that result is taken. Writing
// tap_count or any coefficient clears the delay line at once.
module transposed_fir_filter
    import tfir_pkg::*;
(
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_in_valid,
    output      logic             o_in_ready,
    input  wire t_in_word         i_in_data,
    output      logic             o_out_valid,
    input  wire logic             i_out_ready,
    output      t_out_word        o_out_data,
    input  wire logic             i_cfg_we,
    input  wire logic [CFG_W-1:0] i_cfg_data
);

    t_state r_state, n_state;

    logic [CFG_W-1:0] r_tap_count;
    logic [CNT_W-1:0] w_taps;

    logic signed [SMP_W-1:0] r_coef_mem [MAX_TAPS];
    logic [SUM_W-1:0]        r_ps_mem   [MAX_TAPS];
    logic [MAX_TAPS-1:0]     r_coef_vld;
    logic [MAX_TAPS-1:0]     r_ps_vld;

    logic signed [SMP_W-1:0] r_x;
    logic                    r_bend;
    logic [CNT_W-1:0]        r_rd_idx;

    logic                    r_s1_vld, r_s1_last, r_s1_cok, r_s1_pok;
    logic [TAP_AW-1:0]       r_s1_idx;
    logic signed [SMP_W-1:0] r_coef_q;
    logic [SUM_W-1:0]        r_ps_q;

    logic                     r_s2_vld, r_s2_last;
    logic [TAP_AW-1:0]        r_s2_idx;
    logic signed [PROD_W-1:0] r_prod;
    logic [SUM_W-1:0]         r_ps_d;

    logic [SUM_W-1:0] r_first;
    logic             r_out_vld;
    t_out_word        r_out;

    logic               w_accept, w_smp_go, w_coef_go, w_issue, w_load;
    logic [TAP_AW-1:0]  w_ps_addr;
    logic [SUM_W-1:0]   w_sum;
    logic signed [SMP_W-1:0] w_coef_m;
    logic signed [SUM_W:0]   w_rnd;
    logic signed [SH_W-1:0]  w_sh;
    logic               w_pos_sat, w_neg_sat;

    assign w_taps = (r_tap_count == '0) ? CNT_W'(1) :
                    (32'(r_tap_count) > MAX_TAPS) ? CNT_W'(MAX_TAPS) : CNT_W'(r_tap_count);

    assign o_in_ready = (r_state == ST_IDLE);
    assign w_accept   = i_in_valid && o_in_ready;
    assign w_smp_go   = w_accept && (i_in_data.kind == KIND_SAMPLE);
    assign w_coef_go  = w_accept && (i_in_data.kind == KIND_COEF) &&
                        (32'(i_in_data.coef_index) < MAX_TAPS);
    assign w_issue    = (r_state == ST_RUN) && (r_rd_idx != w_taps);
    assign w_ps_addr  = TAP_AW'(r_rd_idx + CNT_W'(1));

    always_comb begin
        n_state = r_state;
        w_load  = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                if (w_smp_go) n_state = ST_RUN;
            end
            ST_RUN: begin
                if (r_s2_vld && r_s2_last) n_state = ST_DONE;
            end
            ST_DONE: begin
                if (!r_out_vld || i_out_ready) begin
                    w_load  = 1'b1;
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tap_count <= TAP_COUNT_RST;
        end else if (i_cfg_we) begin
            r_tap_count <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_coef_go) begin
            r_coef_mem[TAP_AW'(i_in_data.coef_index)] <= i_in_data.coef_value;
        end
        r_coef_q <= r_coef_mem[r_rd_idx[TAP_AW-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (r_s2_vld) begin
            r_ps_mem[r_s2_idx] <= w_sum;
        end
        r_ps_q <= r_ps_mem[w_ps_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_coef_vld <= '0;
            r_ps_vld   <= '0;
        end else begin
            if (w_coef_go) r_coef_vld[TAP_AW'(i_in_data.coef_index)] <= 1'b1;
            if (i_cfg_we || w_coef_go) begin
                r_ps_vld <= '0;
            end else if (r_s2_vld) begin
                r_ps_vld[r_s2_idx] <= 1'b1;
            end
        end
    end

    // sequencer and tap pipeline
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_idx <= '0;
            r_s1_vld <= 1'b0;
            r_s2_vld <= 1'b0;
        end else begin
            if (w_smp_go) r_rd_idx <= '0;
            else if (w_issue) r_rd_idx <= r_rd_idx + CNT_W'(1);
            r_s1_vld <= w_issue;
            r_s2_vld <= r_s1_vld;
        end
    end

    assign w_coef_m = r_s1_cok ? r_coef_q : '0;
    assign w_sum    = r_ps_d + SUM_W'(r_prod);

    always_ff @(posedge i_clk) begin
        if (w_smp_go) begin
            r_x    <= i_in_data.sample;
            r_bend <= i_in_data.block_end;
        end
        r_s1_idx  <= r_rd_idx[TAP_AW-1:0];
        r_s1_last <= (r_rd_idx == w_taps - CNT_W'(1));
        r_s1_cok  <= r_coef_vld[r_rd_idx[TAP_AW-1:0]];
        r_s1_pok  <= (r_rd_idx != w_taps - CNT_W'(1)) && r_ps_vld[w_ps_addr];
        r_prod    <= w_coef_m * r_x;
        r_ps_d    <= r_s1_pok ? r_ps_q : '0;
        r_s2_idx  <= r_s1_idx;
        r_s2_last <= r_s1_last;
        if (r_s2_vld && (r_s2_idx == '0)) r_first <= w_sum;
    end

    // round half up, saturate
    assign w_rnd     = $signed({r_first[SUM_W-1], r_first}) + (SUM_W+1)'(16'h4000);
    assign w_sh      = SH_W'(w_rnd >>> 15);
    assign w_pos_sat = !w_sh[SH_W-1] && (w_sh[SH_W-2:SMP_W-1] != '0);
    assign w_neg_sat = w_sh[SH_W-1] && (w_sh[SH_W-2:SMP_W-1] != '1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (w_load) begin
            r_out_vld <= 1'b1;
        end else if (i_out_ready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_out.filtered      <= w_pos_sat ? 16'sh7FFF :
                                   w_neg_sat ? 16'sh8000 : w_sh[SMP_W-1:0];
            r_out.clipped       <= w_pos_sat || w_neg_sat;
            r_out.last_of_block <= r_bend;
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_out_data  = r_out;

endmodule

`default_nettype wire

// ----- hdl/tfir_chk.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// tfir_chk
// Port-level checks for the transposed-form FIR filter.
// ----------------------------------------------------------------------------
module tfir_chk
    import tfir_pkg::*;
(
    input wire logic             i_clk,
    input wire logic             i_rst_n,
    input wire logic             i_in_valid,
    input wire logic             o_in_ready,
    input wire t_in_word         i_in_data,
    input wire logic             o_out_valid,
    input wire logic             i_out_ready,
    input wire t_out_word        o_out_data,
    input wire logic             i_cfg_we
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_data))
        else $error("output word dropped or changed while stalled");

    a_busy_after_sample: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready && (i_in_data.kind == KIND_SAMPLE) |=> !o_in_ready)
        else $error("ready after a sample word was taken");

    a_coef_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready && (i_in_data.kind == KIND_COEF) && !o_out_valid
        |=> !o_out_valid)
        else $error("coefficient word produced an output");

    a_clip_value: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.clipped |->
        (o_out_data.filtered == 16'sh7FFF) || (o_out_data.filtered == 16'sh8000))
        else $error("clip flag without a saturated value");

    a_cfg_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cfg_we |-> o_in_ready)
        else $error("tap count written while a word is in flight");

endmodule

bind transposed_fir_filter tfir_chk u_tfir_chk (.*);

`default_nettype wire

// ----- bench/tfir_checker.sv -----
// ----------------------------------------------------------------------------
// tfir_checker
// Watches the sample, result and tap-count ports of the transposed FIR. It
// keeps its own taps, partial sums and tap count and predicts each filtered
// word. Every result word is compared with the oldest prediction. The
// mismatch count and the number of words still due go back to the bench top.
// ----------------------------------------------------------------------------
module tfir_checker
    import tfir_pkg::*;
(
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_in_valid,
    input  wire logic             i_in_ready,
    input  wire t_in_word         i_in_data,
    input  wire logic             i_out_valid,
    input  wire logic             i_out_ready,
    input  wire t_out_word        i_out_data,
    input  wire logic             i_cfg_we,
    input  wire logic [CFG_W-1:0] i_cfg_data,
    output      int               o_errors,
    output      int               o_outstanding
);

    logic [CFG_W-1:0]        tap_count;
    logic signed [SMP_W-1:0] taps [MAX_TAPS];
    logic [SUM_W-1:0]        sums [MAX_TAPS];
    t_out_word               due_words [$];
    int                      errors = 0;

    function automatic void clear_sums();
        for (int j = 0; j < MAX_TAPS; j++) begin
            sums[j] = '0;
        end
    endfunction

    // Advance the delay line by one sample and return the rounded, saturated first sum.
    function automatic t_out_word filter_sample(input t_in_word w);
        int                      n;
        logic [SUM_W-1:0]        upper;
        logic signed [SUM_W-1:0] prod;
        logic signed [SUM_W:0]   rnd;
        logic signed [SUM_W:0]   q;
        t_out_word               r;
        n = (tap_count == 0) ? 1 : (tap_count > MAX_TAPS) ? MAX_TAPS : int'(tap_count);
        for (int j = 0; j < n; j++) begin
            upper = (j + 1 < n) ? sums[j + 1] : '0;
            prod = $signed(taps[j]) * $signed(w.sample);
            sums[j] = upper + prod;
        end
        rnd = $signed(sums[0]) + 41'sd16384;
        q = rnd >>> 15;
        r.clipped = 1'b0;
        if (q > 41'sd32767) begin
            r.filtered = 16'sh7fff;
            r.clipped = 1'b1;
        end else if (q < -41'sd32768) begin
            r.filtered = 16'sh8000;
            r.clipped = 1'b1;
        end else begin
            r.filtered = q[SMP_W-1:0];
        end
        r.last_of_block = w.block_end;
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_out_word want;
        if (!i_rst_n) begin
            tap_count = TAP_COUNT_RST;
            for (int j = 0; j < MAX_TAPS; j++) begin
                taps[j] = '0;
            end
            clear_sums();
            due_words.delete();
        end else begin
            if (i_out_valid && i_out_ready) begin
                if (due_words.size() == 0) begin
                    errors++;
                    $display("%0t: unexpected output word %0d/%0b/%0b", $time,
                             i_out_data.filtered, i_out_data.clipped,
                             i_out_data.last_of_block);
                end else begin
                    want = due_words.pop_front();
                    if (i_out_data.filtered !== want.filtered
                            || i_out_data.clipped !== want.clipped
                            || i_out_data.last_of_block !== want.last_of_block) begin
                        errors++;
                        $display("%0t: expected filtered/clipped/last %0d/%0b/%0b, got %0d/%0b/%0b",
                                 $time, want.filtered, want.clipped, want.last_of_block,
                                 i_out_data.filtered, i_out_data.clipped,
                                 i_out_data.last_of_block);
                    end
                end
            end
            if (i_cfg_we) begin
                tap_count = i_cfg_data;
                clear_sums();
            end
            if (i_in_valid && i_in_ready) begin
                if (i_in_data.kind == KIND_COEF) begin
                    taps[i_in_data.coef_index] = i_in_data.coef_value;
                    clear_sums();
                end else begin
                    due_words.push_back(filter_sample(i_in_data));
                end
            end
        end
        o_errors <= errors;
        o_outstanding <= due_words.size();
    end

endmodule

// ----- bench/tb.sv -----
// ----------------------------------------------------------------------------
// tb
// Bench top for the transposed FIR. Drives a directed set of corner words,
// then phases of tap loads and sample runs under several tap counts, with
// random idle bursts on both channels. Checking is done by tfir_checker and tfir_chk.
// ----------------------------------------------------------------------------
module tb;
    import tfir_pkg::*;

    localparam int TOTAL_WORDS = 850;
    localparam int CALM_AFTER  = 790;
    localparam int SETTLE      = 80;

    logic             clk       = 1'b0;
    logic             rst_n     = 1'b0;
    logic             in_valid  = 1'b0;
    logic             in_ready;
    t_in_word         in_data   = '0;
    logic             out_valid;
    logic             out_ready = 1'b0;
    t_out_word        out_data;
    logic             cfg_we    = 1'b0;
    logic [CFG_W-1:0] cfg_data  = TAP_COUNT_RST;
    int               errors;
    int               outstanding;
    int               sent      = 0;
    int               stall_left = 0;
    bit               calm      = 1'b0;
    bit               quiet     = 1'b0;

    transposed_fir_filter dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (out_data),
        .i_cfg_we    (cfg_we),
        .i_cfg_data  (cfg_data)
    );

    tfir_checker checker_i (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_in_valid    (in_valid),
        .i_in_ready    (in_ready),
        .i_in_data     (in_data),
        .i_out_valid   (out_valid),
        .i_out_ready   (out_ready),
        .i_out_data    (out_data),
        .i_cfg_we      (cfg_we),
        .i_cfg_data    (cfg_data),
        .o_errors      (errors),
        .o_outstanding (outstanding)
    );

    always #6 clk = ~clk;

    initial begin
        #(12 * 800_000);
        $display("Some tests failed");
        $finish;
    end

    always @(posedge clk) begin
        if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            out_ready <= (stall_left == 1);
        end else if (!calm && !quiet && $urandom_range(0, 5) == 0) begin
            stall_left <= $urandom_range(1, 12);
            out_ready <= 1'b0;
        end else begin
            out_ready <= 1'b1;
        end
    end

    function automatic t_in_word sample_word(input logic signed [SMP_W-1:0] x,
                                             input logic bend);
        t_in_word w;
        w.kind       = KIND_SAMPLE;
        w.sample     = x;
        w.coef_index = 6'($urandom);
        w.coef_value = SMP_W'($urandom);
        w.block_end  = bend;
        return w;
    endfunction

    function automatic t_in_word coef_word(input logic [5:0] idx,
                                           input logic signed [SMP_W-1:0] v);
        t_in_word w;
        w.kind       = KIND_COEF;
        w.sample     = SMP_W'($urandom);
        w.coef_index = idx;
        w.coef_value = v;
        w.block_end  = 1'($urandom);
        return w;
    endfunction

    task automatic send_word(input t_in_word w);
        if (!calm && !quiet && $urandom_range(0, 3) == 0) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data <= w;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        sent++;
        calm = (sent >= CALM_AFTER);
    endtask

    // Drain, let the block settle, then load a new tap count.
    task automatic load_tap_count(input logic [CFG_W-1:0] v);
        in_valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0) @(posedge clk);
        repeat (SETTLE) @(posedge clk);
        cfg_we <= 1'b1;
        cfg_data <= v;
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    initial begin
        int                      tap_plan [8];
        int                      phase;
        int                      n_eff;
        logic [CFG_W-1:0]        v;
        logic [5:0]              idx;
        logic signed [SMP_W-1:0] x;
        logic signed [SMP_W-1:0] cv;
        tap_plan = '{1, 0, 64, 2, 127, 7, 65, 33};

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_word(sample_word(16'sh7fff, 1'b0));
        send_word(coef_word(6'd0, 16'sd1));
        send_word(sample_word(16'sd16384, 1'b0));
        send_word(sample_word(-16'sd16384, 1'b1));
        send_word(sample_word(-16'sd16385, 1'b0));
        send_word(coef_word(6'd0, 16'sh8000));
        send_word(sample_word(16'sh8000, 1'b0));
        send_word(sample_word(16'sh7fff, 1'b1));
        send_word(coef_word(6'd63, 16'sh7fff));
        send_word(coef_word(6'd0, 16'sh7fff));
        send_word(coef_word(6'd1, 16'sh7fff));
        send_word(sample_word(16'sh8000, 1'b0));
        send_word(sample_word(16'sh8000, 1'b1));
        send_word(sample_word(16'sh7fff, 1'b0));
        send_word(sample_word(16'sh7fff, 1'b0));
        send_word(sample_word(16'sd0, 1'b0));
        send_word(sample_word(-16'sd1, 1'b1));

        phase = 0;
        while (sent < TOTAL_WORDS) begin
            v = (phase < 8) ? CFG_W'(tap_plan[phase]) : CFG_W'($urandom_range(1, 64));
            phase++;
            load_tap_count(v);
            quiet = ($urandom_range(0, 2) == 0);
            n_eff = (v == 0) ? 1 : (v > MAX_TAPS) ? MAX_TAPS : int'(v);
            repeat ($urandom_range(1, 6)) begin
                if (sent >= TOTAL_WORDS) break;
                idx = ($urandom_range(0, 3) != 0) ? 6'($urandom_range(0, n_eff - 1))
                                                  : 6'($urandom);
                case ($urandom_range(0, 7))
                    0:       cv = 16'sh8000;
                    1:       cv = 16'sh7fff;
                    2, 3:    cv = SMP_W'(int'($urandom_range(0, 2047)) - 1024);
                    default: cv = SMP_W'($urandom);
                endcase
                send_word(coef_word(idx, cv));
            end
            repeat ($urandom_range(30, 110)) begin
                if (sent >= TOTAL_WORDS) break;
                if ($urandom_range(0, 24) == 0) begin
                    send_word(coef_word(6'($urandom), SMP_W'($urandom)));
                end else begin
                    case ($urandom_range(0, 11))
                        0:       x = 16'sh8000;
                        1:       x = 16'sh7fff;
                        2:       x = '0;
                        3:       x = '1;
                        default: x = SMP_W'($urandom);
                    endcase
                    send_word(sample_word(x, $urandom_range(0, 11) == 0));
                end
            end
        end

        in_valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0) @(posedge clk);
        repeat (SETTLE) @(posedge clk);
        if (errors == 0 && outstanding == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

// ----- files.f -----
hdl/tfir_pkg.sv
hdl/transposed_fir_filter.sv
hdl/tfir_chk.sv
bench/tfir_checker.sv
bench/tb.sv
